>>> sv/size_class_buffer_pool_top_assert.svh
// Assertion macros for the size class buffer pool checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SIZE_CLASS_BUFFER_POOL_TOP_ASSERT_SVH
`define SIZE_CLASS_BUFFER_POOL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("size class buffer pool: check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("size class buffer pool: check failed");

`endif

>>> sv/scbp_pkg.sv
`timescale 1ns / 1ps

package scbp_pkg;

  // Fixed field widths of the request and result items.
  localparam int SIZE_W     = 32;
  localparam int HANDLE_W   = 32;
  localparam int RESIDENT_W = 40;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 304;

  // Number of class size registers in the register map.
  localparam int REG_CLASSES = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_SIZE_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_SIZE_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_SIZE_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_SIZE_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASSES_IN_USE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_CLASS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESIDENT   = 3'd6;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DRAIN   = 2'd2,
    KIND_STATS   = 2'd3
  } kind_t;

  // Result outcomes.
  typedef enum logic [3:0] {
    OUT_HIT         = 4'd0,
    OUT_MISS        = 4'd1,
    OUT_OVERSIZED   = 4'd2,
    OUT_CACHED      = 4'd3,
    OUT_FREED       = 4'd4,
    OUT_IGNORED     = 4'd5,
    OUT_DRAINED     = 4'd6,
    OUT_DRAIN_EMPTY = 4'd7,
    OUT_CLEARED     = 4'd8
  } outcome_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT,
    ST_ACT,
    ST_RD,
    ST_OUT,
    ST_DR_MUL,
    ST_DR_SUB,
    ST_DR_SCAN,
    ST_DR_RD
  } state_t;

endpackage

>>> sv/scbp_stack_mem.sv
`timescale 1ns / 1ps

// Single-port handle store: one write or one registered read per cycle.
module scbp_stack_mem
  import scbp_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic                re,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [HANDLE_W-1:0] wdata,
  output logic [HANDLE_W-1:0] rdata
);

  logic [HANDLE_W-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> sv/size_class_buffer_pool_top.sv
`timescale 1ns / 1ps

// Size class buffer pool. It takes one request at a time, and the input is not ready
// until its results are under way. One size comparator is walked over the enabled
// classes, one class a cycle, and the handle stacks live in a single-port memory. An
// acquire or a non-null release walks to the first class that fits, and a hit then
// reads the top of its stack; a null release or a statistics reset skips the walk. A
// drain first works out the resident bytes left, a multiply and then a subtract per
// class through the shared multiplier and subtractor, then walks the stacks one cached
// handle at a time, class by class, and waits while the output is stalled. The handle
// store needs no clearing after reset.
module size_class_buffer_pool_top
  import scbp_pkg::*;
#(
  parameter int NUM_CLASSES = 4,
  parameter int STACK_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request channel.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: request_size [31:0], handle [63:32], release_capacity [95:64].
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: kind [1:0].
  input  logic [1:0]            s_tuser,
  // Result channel.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: class_index [1:0], capacity [33:2], buffer_handle [65:34],
  // resident_total [105:66], acquire_count [137:106], hit_count [169:138],
  // miss_count [201:170], oversize_count [233:202], release_count [265:234],
  // freed_count [297:266], zero padding [303:298].
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: outcome [3:0].
  output logic [3:0]            m_tuser,
  output logic                  m_tlast,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W   = ($clog2(NUM_CLASSES + 1) < 3) ? 3 : $clog2(NUM_CLASSES + 1);
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH   = NUM_CLASSES * STACK_DEPTH;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W  = FILL_W + SIZE_W;
  localparam logic [CNT_W-1:0] LAST_CLASS = CNT_W'(NUM_CLASSES - 1);
  localparam logic [CNT_W-1:0] SCAN_END   = CNT_W'(NUM_CLASSES);

  // Configuration registers.
  logic [SIZE_W-1:0]     class_size [0:REG_CLASSES-1];
  logic [2:0]            classes_in_use;
  logic [4:0]            max_per_class;
  logic [RESIDENT_W-1:0] max_resident;

  // Pool state.
  logic [FILL_W-1:0]     fill [0:NUM_CLASSES-1];
  logic [RESIDENT_W-1:0] resident;
  logic [COUNT_W-1:0]    acquires, hits, misses, oversized, releases, frees;

  // Sequencer and working registers.
  state_t                state, state_next;
  kind_t                 kind_q;
  logic [SIZE_W-1:0]     key;
  logic [HANDLE_W-1:0]   hnd_q;
  logic [CNT_W-1:0]      idx;
  logic [FILL_W-1:0]     slot;
  logic                  found;
  logic                  any_out;
  logic [PROD_W-1:0]     prod;

  // Pending result.
  outcome_t              res_outcome;
  logic [1:0]            res_class;
  logic [SIZE_W-1:0]     res_cap;
  logic [HANDLE_W-1:0]   res_handle;

  // Memory port.
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_addr;
  logic [HANDLE_W-1:0]   mem_q;

  // Control strobes.
  logic                  out_load, out_last, out_free;

  // Shared datapath terms.
  kind_t                 in_kind;
  logic [SIZE_W-1:0]     in_req, in_hnd, in_rcap;
  logic [2:0]            active;
  logic [CLS_W-1:0]      cls_sel;
  logic [SIZE_W-1:0]     cur_size;
  logic [FILL_W-1:0]     fill_cur;
  logic [FILL_W-1:0]     limit;
  logic                  in_range, size_ge, match, room, budget, scan_more;
  logic [RESIDENT_W-1:0] res_minus_cap, res_minus_prod;
  logic [FILL_W-1:0]     mem_off;
  logic [31:0]           mem_base;

  assign in_kind  = kind_t'(s_tuser);
  assign in_req   = s_tdata[31:0];
  assign in_hnd   = s_tdata[63:32];
  assign in_rcap  = s_tdata[95:64];
  assign out_free = !m_tvalid || m_tready;

  // Enabled class count, bounded by the register map and the instance size.
  always_comb begin
    active = classes_in_use;
    if (active > 3'(REG_CLASSES)) active = 3'(REG_CLASSES);
    if (32'(active) > NUM_CLASSES) active = 3'(NUM_CLASSES);
  end

  // Stack limit, bounded by the stack depth.
  assign limit = (32'(max_per_class) > STACK_DEPTH) ? FILL_W'(STACK_DEPTH)
                                                    : FILL_W'(max_per_class);

  // The shared comparator and the terms around the class under the pointer.
  assign cls_sel   = idx[CLS_W-1:0];
  assign cur_size  = (idx < CNT_W'(REG_CLASSES)) ? class_size[idx[1:0]] : '0;
  assign fill_cur  = fill[cls_sel];
  assign in_range  = idx < CNT_W'(active);
  assign size_ge   = cur_size >= key;
  assign match     = found && (cur_size == key);
  assign room      = fill_cur < limit;
  assign budget    = ({1'b0, resident} + (RESIDENT_W + 1)'(key)) <= {1'b0, max_resident};
  assign scan_more = (idx != SCAN_END) && (slot < fill_cur);
  assign res_minus_cap  = (resident >= RESIDENT_W'(cur_size))
                        ? resident - RESIDENT_W'(cur_size) : '0;
  assign res_minus_prod = ((RESIDENT_W + 1)'(resident) >= (RESIDENT_W + 1)'(prod))
                        ? resident - RESIDENT_W'(prod) : '0;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (in_kind)
            KIND_ACQUIRE: state_next = ST_FIT;
            KIND_RELEASE: state_next = (in_hnd == '0) ? ST_OUT : ST_FIT;
            KIND_DRAIN:   state_next = ST_DR_MUL;
            KIND_STATS:   state_next = ST_OUT;
          endcase
        end
      end
      ST_FIT: begin
        if (!in_range || size_ge) state_next = ST_ACT;
      end
      ST_ACT: begin
        if (kind_q == KIND_ACQUIRE && found && fill_cur != '0) state_next = ST_RD;
        else state_next = ST_OUT;
      end
      ST_RD:     state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_DR_MUL: state_next = ST_DR_SUB;
      ST_DR_SUB: begin
        if (idx == LAST_CLASS) state_next = ST_DR_SCAN;
        else state_next = ST_DR_MUL;
      end
      ST_DR_SCAN: begin
        if (idx == SCAN_END) state_next = ST_OUT;
        else if (scan_more) state_next = ST_DR_RD;
      end
      ST_DR_RD: begin
        if (out_free) state_next = ST_DR_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_off  = slot;
    out_load = 1'b0;
    out_last = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_ACT: begin
        if (kind_q == KIND_ACQUIRE) begin
          mem_re  = found && fill_cur != '0;
          mem_off = fill_cur - FILL_W'(1);
        end else begin
          mem_we  = match && room && budget;
          mem_off = fill_cur;
        end
      end
      ST_OUT: begin
        out_load = out_free;
        out_last = 1'b1;
      end
      ST_DR_SCAN: mem_re = scan_more;
      ST_DR_RD:   out_load = out_free && any_out;
      default: ;
    endcase
  end

  assign mem_base = 32'(cls_sel) * STACK_DEPTH;
  assign mem_addr = ADDR_W'(mem_base + 32'(mem_off));

  scbp_stack_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (hnd_q),
    .rdata (mem_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_size[0]  <= 32'd256;
      class_size[1]  <= 32'd4096;
      class_size[2]  <= 32'd65536;
      class_size[3]  <= 32'd1048576;
      classes_in_use <= 3'd4;
      max_per_class  <= 5'd16;
      max_resident   <= 40'd67108864;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_CLASS_SIZE_0, CFG_CLASS_SIZE_1, CFG_CLASS_SIZE_2, CFG_CLASS_SIZE_3:
          class_size[cfg_index[1:0]] <= cfg_data[SIZE_W-1:0];
        CFG_CLASSES_IN_USE: classes_in_use <= cfg_data[2:0];
        CFG_MAX_PER_CLASS:  max_per_class  <= cfg_data[4:0];
        CFG_MAX_RESIDENT:   max_resident   <= cfg_data[RESIDENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Stack fills, resident bytes and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) fill[c] <= '0;
      resident  <= '0;
      acquires  <= '0;
      hits      <= '0;
      misses    <= '0;
      oversized <= '0;
      releases  <= '0;
      frees     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid && in_kind == KIND_STATS) begin
            acquires  <= '0;
            hits      <= '0;
            misses    <= '0;
            oversized <= '0;
            releases  <= '0;
            frees     <= '0;
          end
        end
        ST_ACT: begin
          if (kind_q == KIND_ACQUIRE) begin
            acquires <= acquires + 1'b1;
            if (!found) begin
              oversized <= oversized + 1'b1;
            end else if (fill_cur != '0) begin
              fill[cls_sel] <= fill_cur - FILL_W'(1);
              hits          <= hits + 1'b1;
              resident      <= res_minus_cap;
            end else begin
              misses <= misses + 1'b1;
            end
          end else begin
            releases <= releases + 1'b1;
            if (match && room && budget) begin
              fill[cls_sel] <= fill_cur + FILL_W'(1);
              resident      <= resident + RESIDENT_W'(key);
            end else begin
              frees <= frees + 1'b1;
            end
          end
        end
        ST_DR_SUB: resident <= res_minus_prod;
        ST_DR_SCAN: begin
          if (idx == SCAN_END) begin
            for (int c = 0; c < NUM_CLASSES; c++) fill[c] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and the pending result.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          kind_q  <= in_kind;
          key     <= (in_kind == KIND_ACQUIRE)
                   ? ((in_req == '0) ? SIZE_W'(1) : in_req) : in_rcap;
          hnd_q   <= in_hnd;
          idx     <= '0;
          slot    <= '0;
          found   <= 1'b0;
          any_out <= 1'b0;
          res_class  <= '0;
          res_cap    <= '0;
          res_handle <= '0;
          res_outcome <= (in_kind == KIND_STATS) ? OUT_CLEARED : OUT_IGNORED;
        end
      end
      ST_FIT: begin
        if (in_range && size_ge) found <= 1'b1;
        else if (in_range) idx <= idx + CNT_W'(1);
      end
      ST_ACT: begin
        res_handle <= '0;
        if (kind_q == KIND_ACQUIRE) begin
          if (!found) begin
            res_outcome <= OUT_OVERSIZED;
            res_class   <= '0;
            res_cap     <= key;
          end else begin
            res_outcome <= (fill_cur != '0) ? OUT_HIT : OUT_MISS;
            res_class   <= idx[1:0];
            res_cap     <= cur_size;
          end
        end else begin
          res_outcome <= (match && room && budget) ? OUT_CACHED : OUT_FREED;
          res_class   <= found ? idx[1:0] : 2'd0;
          res_cap     <= key;
        end
      end
      ST_RD: res_handle <= mem_q;
      ST_DR_MUL: prod <= fill_cur * cur_size;
      ST_DR_SUB: idx <= (idx == LAST_CLASS) ? '0 : idx + CNT_W'(1);
      ST_DR_SCAN: begin
        if (idx == SCAN_END) begin
          if (!any_out) begin
            res_outcome <= OUT_DRAIN_EMPTY;
            res_class   <= '0;
            res_cap     <= '0;
            res_handle  <= '0;
          end
        end else if (!scan_more) begin
          idx  <= idx + CNT_W'(1);
          slot <= '0;
        end
      end
      ST_DR_RD: begin
        if (out_free) begin
          res_outcome <= OUT_DRAINED;
          res_class   <= idx[1:0];
          res_cap     <= cur_size;
          res_handle  <= mem_q;
          any_out     <= 1'b1;
          slot        <= slot + FILL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register, loaded with the pending result and the live statistics.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_outcome;
      m_tlast <= out_last;
      m_tdata <= {6'd0, frees, releases, oversized, misses, hits, acquires,
                  resident, res_handle, res_cap, res_class};
    end
  end

endmodule

>>> sv/scbp_checker.sv
`timescale 1ns / 1ps

`include "size_class_buffer_pool_top_assert.svh"

// Port-level checks of the size class buffer pool.
module scbp_checker
  import scbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [3:0]            m_tuser,
  input logic                  m_tlast
);

  // A request occupies the block, so ready drops right after an accept.
  `SCBP_ASSERT_NEXT(busy_after_accept, s_tvalid && s_tready, !s_tready)

  // Only drained handles may be followed by further results of the same request.
  `SCBP_ASSERT_NOW(single_results_last, m_tvalid && m_tuser != OUT_DRAINED, m_tlast)

  // A statistics reset reports all six counters as zero.
  `SCBP_ASSERT_NOW(cleared_counts_zero, m_tvalid && m_tuser == OUT_CLEARED,
                   m_tdata[297:106] == '0)

  // A stalled result holds its contents.
  `SCBP_ASSERT_NEXT(stalled_result_holds, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind size_class_buffer_pool_top scbp_checker u_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import scbp_pkg::*;

  localparam int NUM_CLASSES    = 4;
  localparam int STACK_DEPTH    = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PRINT_LIMIT    = 200;
  // Index 7 is not part of the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  // One request as the sender sees it; pause holds it back until no result is pending.
  typedef struct {
    kind_t       kind;
    logic [31:0] size;
    logic [31:0] hnd;
    logic [31:0] rcap;
    bit          pause;
  } pool_request_t;

  // One result item with every field at its port width.
  typedef struct {
    outcome_t    outcome;
    logic [1:0]  cls;
    logic [31:0] cap;
    logic [31:0] hnd;
    logic        last;
    logic [39:0] resident;
    logic [31:0] acq;
    logic [31:0] hit;
    logic [31:0] miss;
    logic [31:0] over;
    logic [31:0] rel;
    logic [31:0] freed;
  } pool_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [3:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the configuration.
  logic [31:0] class_bytes [REG_CLASSES];
  logic [2:0]  enabled_classes;
  logic [4:0]  per_class_cap;
  logic [39:0] byte_budget;

  // Predictor copy of the pool state.
  logic [31:0] handle_store [NUM_CLASSES*STACK_DEPTH];
  int unsigned depth_used [NUM_CLASSES];
  logic [39:0] bytes_cached;
  logic [31:0] n_acquire, n_hit, n_miss, n_oversize, n_release, n_freed;

  pool_request_t requests_to_send[$];
  pool_result_t  outcomes_due[$];
  pool_request_t current_req;
  int            queued_total = 0;
  int            accepted_total = 0;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 38;
  int            recv_idle_pct = 70;

  size_class_buffer_pool_top #(
    .NUM_CLASSES(NUM_CLASSES),
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bring the predictor to its state after reset.
  task automatic reset_pool_model();
    class_bytes[0]  = 32'd256;
    class_bytes[1]  = 32'd4096;
    class_bytes[2]  = 32'd65536;
    class_bytes[3]  = 32'd1048576;
    enabled_classes = 3'd4;
    per_class_cap   = 5'd16;
    byte_budget     = 40'd67108864;
    foreach (handle_store[i]) handle_store[i] = '0;
    foreach (depth_used[i]) depth_used[i] = 0;
    bytes_cached = '0;
    n_acquire = '0; n_hit = '0; n_miss = '0;
    n_oversize = '0; n_release = '0; n_freed = '0;
  endtask

  // Mirror one register write in the predictor.
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [39:0] value);
    case (idx)
      CFG_CLASS_SIZE_0:   class_bytes[0] = value[31:0];
      CFG_CLASS_SIZE_1:   class_bytes[1] = value[31:0];
      CFG_CLASS_SIZE_2:   class_bytes[2] = value[31:0];
      CFG_CLASS_SIZE_3:   class_bytes[3] = value[31:0];
      CFG_CLASSES_IN_USE: enabled_classes = value[2:0];
      CFG_MAX_PER_CLASS:  per_class_cap = value[4:0];
      CFG_MAX_RESIDENT:   byte_budget = value;
      default: ;
    endcase
  endtask

  // First enabled class large enough for the request, or -1.
  function automatic int first_fit(input logic [31:0] want);
    int n;
    n = enabled_classes;
    if (n > REG_CLASSES) n = REG_CLASSES;
    if (n > NUM_CLASSES) n = NUM_CLASSES;
    for (int i = 0; i < n; i++)
      if (class_bytes[i] >= want) return i;
    return -1;
  endfunction

  // Resident bytes after taking an amount away, floored at zero.
  function automatic logic [39:0] less_resident(input logic [63:0] amount);
    if ({24'd0, bytes_cached} >= amount) return bytes_cached - amount[39:0];
    return '0;
  endfunction

  function automatic pool_result_t make_result(input outcome_t o, input int cls,
                                               input logic [31:0] cap,
                                               input logic [31:0] hnd);
    pool_result_t r;
    r.outcome  = o;
    r.cls      = cls[1:0];
    r.cap      = cap;
    r.hnd      = hnd;
    r.last     = 1'b0;
    r.resident = '0;
    r.acq      = '0;
    r.hit      = '0;
    r.miss     = '0;
    r.over     = '0;
    r.rel      = '0;
    r.freed    = '0;
    return r;
  endfunction

  // Work out the results of one accepted request and queue them.
  task automatic compute_pool_results(input pool_request_t rq);
    pool_result_t batch[$];
    logic [31:0]  want;
    logic [40:0]  sum;
    logic [63:0]  amount;
    int           c;
    int           lim;
    want = rq.size;
    lim  = (per_class_cap > STACK_DEPTH) ? STACK_DEPTH : per_class_cap;
    case (rq.kind)
      KIND_ACQUIRE: begin
        if (want == 0) want = 1;
        c = first_fit(want);
        n_acquire++;
        if (c < 0) begin
          n_oversize++;
          batch.insert(batch.size(), make_result(OUT_OVERSIZED, 0, want, '0));
        end else if (depth_used[c] > 0) begin
          depth_used[c]--;
          n_hit++;
          bytes_cached = less_resident({32'd0, class_bytes[c]});
          batch.insert(batch.size(), make_result(OUT_HIT, c, class_bytes[c],
                                      handle_store[c*STACK_DEPTH + depth_used[c]]));
        end else begin
          n_miss++;
          batch.insert(batch.size(), make_result(OUT_MISS, c, class_bytes[c], '0));
        end
      end
      KIND_RELEASE: begin
        if (rq.hnd == 0) begin
          batch.insert(batch.size(), make_result(OUT_IGNORED, 0, '0, '0));
        end else begin
          c = first_fit(rq.rcap);
          n_release++;
          if (c < 0 || class_bytes[c] != rq.rcap) begin
            n_freed++;
            batch.insert(batch.size(),
                         make_result(OUT_FREED, (c < 0) ? 0 : c, rq.rcap, '0));
          end else begin
            sum = {1'b0, bytes_cached} + {9'd0, rq.rcap};
            if (depth_used[c] < lim && sum <= {1'b0, byte_budget}) begin
              handle_store[c*STACK_DEPTH + depth_used[c]] = rq.hnd;
              depth_used[c]++;
              bytes_cached = sum[39:0];
              batch.insert(batch.size(), make_result(OUT_CACHED, c, rq.rcap, '0));
            end else begin
              n_freed++;
              batch.insert(batch.size(), make_result(OUT_FREED, c, rq.rcap, '0));
            end
          end
        end
      end
      KIND_DRAIN: begin
        // Every class is walked, enabled or not, oldest entry first.
        for (int k = 0; k < NUM_CLASSES; k++) begin
          for (int i = 0; i < depth_used[k]; i++)
            batch.insert(batch.size(), make_result(OUT_DRAINED, k, class_bytes[k],
                                        handle_store[k*STACK_DEPTH + i]));
          if (depth_used[k] > 0) begin
            amount = depth_used[k];
            amount = amount * class_bytes[k];
            bytes_cached = less_resident(amount);
          end
          depth_used[k] = 0;
        end
        if (batch.size() == 0)
          batch.insert(batch.size(), make_result(OUT_DRAIN_EMPTY, 0, '0, '0));
      end
      default: begin
        n_acquire = '0; n_hit = '0; n_miss = '0;
        n_oversize = '0; n_release = '0; n_freed = '0;
        batch.insert(batch.size(), make_result(OUT_CLEARED, 0, '0, '0));
      end
    endcase
    // Resident bytes and counters carry their values after the whole request.
    foreach (batch[i]) begin
      batch[i].last     = (i == batch.size() - 1);
      batch[i].resident = bytes_cached;
      batch[i].acq      = n_acquire;
      batch[i].hit      = n_hit;
      batch[i].miss     = n_miss;
      batch[i].over     = n_oversize;
      batch[i].rel      = n_release;
      batch[i].freed    = n_freed;
      outcomes_due.insert(outcomes_due.size(), batch[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Request driver: presents queued requests and predicts each one on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        compute_pool_results(current_req);
        accepted_total++;
      end
      if (!s_tvalid || s_tready) begin
        if (requests_to_send.size() != 0 &&
            !(requests_to_send[0].pause && outcomes_due.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          current_req = requests_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {current_req.rcap, current_req.hnd, current_req.size};
          s_tuser  <= current_req.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    pool_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with nothing predicted", m_tuser, '0);
        end else begin
          want = outcomes_due.pop_front();
          check_field("outcome", m_tuser, want.outcome);
          check_field("class_index", m_tdata[1:0], want.cls);
          check_field("capacity", m_tdata[33:2], want.cap);
          check_field("buffer_handle", m_tdata[65:34], want.hnd);
          check_field("last", m_tlast, want.last);
          check_field("resident byte total", m_tdata[105:66], want.resident);
          check_field("acquire_count", m_tdata[137:106], want.acq);
          check_field("hit_count", m_tdata[169:138], want.hit);
          check_field("miss_count", m_tdata[201:170], want.miss);
          check_field("oversize_count", m_tdata[233:202], want.over);
          check_field("release_count", m_tdata[265:234], want.rel);
          check_field("freed_count", m_tdata[297:266], want.freed);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when neither side has moved a request for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic pool_request_t make_req(input kind_t k, input logic [31:0] size,
                                             input logic [31:0] hnd,
                                             input logic [31:0] rcap);
    pool_request_t r;
    r.kind  = k;
    r.size  = size;
    r.hnd   = hnd;
    r.rcap  = rcap;
    r.pause = 1'b0;
    return r;
  endfunction

  // Mostly well-formed traffic around the configured class sizes, some noise.
  function automatic pool_request_t random_request();
    pool_request_t r;
    int            pick;
    logic [31:0]   near;
    pick = $urandom_range(99);
    near = class_bytes[$urandom_range(REG_CLASSES-1)];
    r = make_req(KIND_ACQUIRE, $urandom, $urandom, $urandom);
    if (pick < 38) begin
      case ($urandom_range(9))
        0: r.size = '0;
        1: r.size = '1;
        2: ;
        3, 4, 5: r.size = near;
        6: r.size = near + 1;
        7: r.size = near - 1;
        default: r.size = $urandom_range(near, 1);
      endcase
    end else if (pick < 80) begin
      r.kind = KIND_RELEASE;
      if ($urandom_range(9) == 0) r.hnd = '0;
      case ($urandom_range(9))
        0: r.rcap = near + 1;
        1: r.rcap = '0;
        2: ;
        default: r.rcap = near;
      endcase
    end else if (pick < 86) begin
      r.kind = KIND_DRAIN;
    end else if (pick < 89) begin
      r.kind = KIND_STATS;
    end else begin
      r.kind = kind_t'($urandom_range(3));
    end
    return r;
  endfunction

  task automatic queue_request(input pool_request_t r);
    requests_to_send.insert(requests_to_send.size(), r);
    queued_total++;
  endtask

  // Wait until every request has gone in and every result has come out.
  task automatic wait_pool_idle();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || accepted_total != queued_total ||
           outcomes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [39:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    apply_reg(idx, value);
  endtask

  // Write a whole register setting while the pool is idle.
  task automatic load_setting(input int which);
    logic [31:0] sz [REG_CLASSES];
    logic [2:0]  ncls;
    logic [4:0]  lim;
    logic [39:0] bud;
    case (which)
      1: begin
        sz = '{32'd1, 32'd2, 32'd3, 32'd4};
        ncls = 3'd4; lim = 5'd16; bud = '1;
      end
      2: begin
        // Unordered and repeated sizes; class and depth limits above range.
        sz = '{32'd64, 32'd64, 32'hFFFF_FFFF, 32'd100};
        ncls = 3'd7; lim = 5'd31; bud = 40'd2000;
      end
      3: begin
        sz = '{32'd512, 32'd1024, 32'd2048, 32'd4096};
        ncls = 3'd0; lim = 5'd0; bud = '0;
      end
      4: begin
        sz[0] = $urandom_range(1000, 1);
        sz[1] = sz[0] + $urandom_range(1000, 1);
        sz[2] = sz[1] + $urandom_range(1000, 1);
        sz[3] = sz[2] + $urandom_range(1000, 1);
        ncls = 3'd3; lim = 5'd5; bud = $urandom_range(20000, 500);
      end
      5: begin
        sz = '{32'hFFFF_FFFC, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        ncls = 3'd4; lim = 5'd16; bud = 40'h03_0000_0000;
      end
      default: begin
        sz = '{32'd256, 32'd4096, 32'd65536, 32'd1048576};
        ncls = 3'd5; lim = 5'd17; bud = 40'd67108864;
        write_reg(CFG_UNMAPPED, {8'd0, $urandom});
      end
    endcase
    write_reg(CFG_CLASS_SIZE_0, {8'd0, sz[0]});
    write_reg(CFG_CLASS_SIZE_1, {8'd0, sz[1]});
    write_reg(CFG_CLASS_SIZE_2, {8'd0, sz[2]});
    write_reg(CFG_CLASS_SIZE_3, {8'd0, sz[3]});
    write_reg(CFG_CLASSES_IN_USE, {37'd0, ncls});
    write_reg(CFG_MAX_PER_CLASS, {35'd0, lim});
    write_reg(CFG_MAX_RESIDENT, bud);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus sequence: directed requests under the reset setting, then random phases.
  initial begin
    pool_request_t r;
    int            n_items;
    int            pause_at;
    reset_pool_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty drain, size extremes, release cases, LIFO hits, clear.
    queue_request(make_req(KIND_DRAIN, '0, '0, '0));
    queue_request(make_req(KIND_ACQUIRE, '0, '0, '0));
    queue_request(make_req(KIND_ACQUIRE, 32'd256, '0, '0));
    queue_request(make_req(KIND_ACQUIRE, 32'd257, '0, '0));
    queue_request(make_req(KIND_ACQUIRE, 32'd1048577, '0, '0));
    queue_request(make_req(KIND_ACQUIRE, '1, '1, '1));
    queue_request(make_req(KIND_RELEASE, '0, '0, 32'd256));
    queue_request(make_req(KIND_RELEASE, '0, '1, 32'd256));
    queue_request(make_req(KIND_RELEASE, '0, 32'd1, 32'd256));
    queue_request(make_req(KIND_RELEASE, '0, $urandom, 32'd300));
    queue_request(make_req(KIND_RELEASE, '0, $urandom, '1));
    queue_request(make_req(KIND_RELEASE, '0, $urandom, '0));
    queue_request(make_req(KIND_RELEASE, '0, 32'h8000_0000, 32'd1048576));
    queue_request(make_req(KIND_RELEASE, '0, $urandom, 32'd4096));
    queue_request(make_req(KIND_ACQUIRE, 32'd1, '0, '0));
    queue_request(make_req(KIND_ACQUIRE, 32'd4000, '0, '0));
    r = make_req(KIND_STATS, $urandom, $urandom, $urandom);
    r.pause = 1'b1;
    queue_request(r);
    queue_request(make_req(KIND_RELEASE, '0, 32'h5555_AAAA, 32'd65536));
    queue_request(make_req(KIND_DRAIN, '1, '1, '1));
    queue_request(make_req(KIND_DRAIN, '0, '0, '0));
    queue_request(make_req(KIND_ACQUIRE, 32'd1048576, '0, '0));
    wait_pool_idle();

    // Random phases, each under its own register setting.
    for (int phase = 1; phase <= 6; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 38;
      end
      if (phase == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_setting(phase);
      n_items  = (phase == 3) ? 20 : 60;
      pause_at = $urandom_range(n_items - 1, 5);
      for (int i = 0; i < n_items; i++) begin
        r = random_request();
        r.pause = (i == pause_at);
        queue_request(r);
      end
      wait_pool_idle();
    end

    if (outcomes_due.size() != 0)
      report_mismatch("results never delivered", outcomes_due.size(), '0);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
